@@ src/quadrature_pid_stepper_position_loop_macros.svh @@
// Assertion macros for the position loop
`ifndef QUADRATURE_PID_STEPPER_POSITION_LOOP_MACROS_SVH
`define QUADRATURE_PID_STEPPER_POSITION_LOOP_MACROS_SVH
`define QPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define QPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/qps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qps_pkg;
  localparam int unsigned TickHz   = 1000000;
  localparam int          RateMax  = 1000000;
  localparam int unsigned HalfMax  = 524287;
  localparam int unsigned DivBits  = 21;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENC, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_RATE,
    ST_STEP, ST_DIV, ST_HP, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_SAMPLE = 2'd0, PH_HIGH = 2'd1, PH_LOW = 2'd2, PH_WAIT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_KP, REG_KI, REG_KD, REG_ILIM, REG_CPER, REG_MINHP, REG_TPR, REG_IDLE
  } reg_e;

  typedef struct packed {
    logic load;
    logic enc;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic rate;
    logic step;
    logic div;
    logic hp;
  } cmd_t;

  typedef struct packed {
    logic pid_due;
    logic need_div;
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [23:0]        ilim;
    logic [15:0]        cper;
    logic [15:0]        minhp;
    logic [14:0]        tpr;
    logic [15:0]        idle;
  } cfg_t;

  function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
    logic signed [1:0] r;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: r = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: r = 2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ src/qps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qps_ctrl import qps_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_fire_i,
  input  wire  out_busy_i,
  input  stat_t stat_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic out_load_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire_i) state_d = ST_ENC;
      ST_ENC:   state_d = stat_i.pid_due ? ST_MUL_P : ST_STEP;
      ST_MUL_P: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_RATE;
      ST_RATE:  state_d = ST_STEP;
      ST_STEP:  state_d = stat_i.need_div ? ST_DIV : ST_OUT;
      ST_DIV:   if (stat_i.div_done) state_d = ST_HP;
      ST_HP:    state_d = ST_OUT;
      ST_OUT:   if (!out_busy_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_fire_i;
    busy_o = (state_q != ST_IDLE);
    out_load_o = 1'b0;
    unique case (state_q)
      ST_ENC:   cmd_o.enc = 1'b1;
      ST_MUL_P: cmd_o.mul_p = 1'b1;
      ST_MUL_I: cmd_o.mul_i = 1'b1;
      ST_MUL_D: cmd_o.mul_d = 1'b1;
      ST_RATE:  cmd_o.rate = 1'b1;
      ST_STEP:  cmd_o.step = 1'b1;
      ST_DIV:   cmd_o.div = 1'b1;
      ST_HP:    cmd_o.hp = 1'b1;
      ST_OUT:   out_load_o = !out_busy_i;
      default:  ;
    endcase
  end
endmodule
`default_nettype wire

@@ src/qps_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qps_datapath import qps_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cmd_t                cmd_i,
  input  cfg_t                cfg_i,
  input  wire                 enc_a_i,
  input  wire                 enc_b_i,
  input  wire signed [13:0]   target_i,
  output stat_t               stat_o,
  output logic                step_o,
  output logic                dir_o,
  output logic signed [14:0]  pos_o,
  output logic signed [20:0]  rate_o,
  output logic signed [15:0]  err_o
);
  logic [1:0]         ab_q, last_ab_q;
  logic signed [13:0] tgt_q;
  logic signed [14:0] pos_q;
  logic signed [15:0] prev_err_q, err_q;
  logic signed [24:0] esum_q;
  logic [15:0]        pcnt_q;
  logic signed [20:0] rate_q;
  logic [18:0]        half_q, pcount_q;
  phase_e             phase_q;
  logic               dir_q;
  logic signed [41:0] acc_q;
  logic signed [16:0] ediff_q;
  // restoring divider: TickHz / (2*mag)
  logic [DivBits-1:0] quo_q;
  logic [21:0]        rem_q;
  logic [21:0]        dvs_q;
  logic [4:0]         dcnt_q;

  logic [15:0] cper_e, minhp_e, idle_e;
  logic signed [15:0] rev;
  assign cper_e  = (cfg_i.cper == 16'd0) ? 16'd1 : cfg_i.cper;
  assign minhp_e = (cfg_i.minhp == 16'd0) ? 16'd1 : cfg_i.minhp;
  assign idle_e  = (cfg_i.idle == 16'd0) ? 16'd1 : cfg_i.idle;
  always_comb begin
    if (cfg_i.tpr < 15'd16) rev = 16'sd16;
    else if (cfg_i.tpr > 15'd16384) rev = 16'sd16384;
    else rev = signed'({1'b0, cfg_i.tpr});
  end

  logic signed [15:0] pos_step, pos2;
  logic signed [15:0] err_c;
  logic signed [25:0] sum_c, lim_c;
  logic signed [24:0] sum_cl;
  assign pos_step = 16'(pos_q) + 16'(quad_delta({last_ab_q, ab_q}));
  assign pos2 = pos_step <<< 1;
  assign err_c = 16'(tgt_q) - 16'(pos_q);
  assign sum_c = 26'(esum_q) + 26'(err_c);
  assign lim_c = signed'({2'b00, cfg_i.ilim});
  always_comb begin
    if (sum_c > lim_c) sum_cl = 25'(lim_c);
    else if (sum_c < -lim_c) sum_cl = 25'(-lim_c);
    else sum_cl = 25'(sum_c);
  end

  logic signed [41:0] q_c;
  assign q_c = (acc_q + ((acc_q < 0) ? 42'sd255 : 42'sd0)) >>> 8;

  // step phase advance
  phase_e ph_n;
  logic [18:0] pc_n;
  always_comb begin
    ph_n = phase_q;
    pc_n = pcount_q;
    if (phase_q != PH_SAMPLE) begin
      if (pc_n != 19'd0) pc_n = pc_n - 19'd1;
      if (pc_n == 19'd0) begin
        if (phase_q == PH_HIGH) begin
          ph_n = PH_LOW;
          pc_n = half_q;
        end else begin
          ph_n = PH_SAMPLE;
        end
      end
    end
  end

  logic [20:0] mag;
  assign mag = 21'(rate_q < 0 ? -rate_q : rate_q);
  logic [21:0] rem_sh;
  assign rem_sh = {rem_q[20:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ab_q <= '0; pos_q <= '0; prev_err_q <= '0; esum_q <= '0;
      pcnt_q <= '0; rate_q <= '0; half_q <= '0; pcount_q <= '0;
      phase_q <= PH_SAMPLE; dir_q <= 1'b0; dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ab_q  <= {enc_a_i, enc_b_i};
        tgt_q <= target_i;
      end
      if (cmd_i.enc) begin
        if (pos2 > rev) pos_q <= 15'(pos_step - rev);
        else if (pos2 < -rev) pos_q <= 15'(pos_step + rev);
        else pos_q <= 15'(pos_step);
        last_ab_q <= ab_q;
        if (pcnt_q + 16'd1 >= cper_e) pcnt_q <= '0;
        else pcnt_q <= pcnt_q + 16'd1;
      end
      if (cmd_i.mul_p) begin
        err_q   <= err_c;
        esum_q  <= sum_cl;
        ediff_q <= 17'(err_c) - 17'(prev_err_q);
        acc_q   <= 42'(cfg_i.kp * err_c);
      end
      if (cmd_i.mul_i) acc_q <= acc_q + 42'(cfg_i.ki * esum_q);
      if (cmd_i.mul_d) acc_q <= acc_q + 42'(cfg_i.kd * ediff_q);
      if (cmd_i.rate) begin
        if (q_c > 42'sd1000000) rate_q <= 21'(RateMax);
        else if (q_c < -42'sd1000000) rate_q <= 21'(-RateMax);
        else rate_q <= 21'(q_c);
        prev_err_q <= err_q;
      end
      if (cmd_i.step) begin
        if (ph_n == PH_SAMPLE && rate_q == 21'sd0) begin
          phase_q  <= PH_WAIT;
          pcount_q <= 19'(idle_e);
        end else begin
          phase_q  <= ph_n;
          pcount_q <= pc_n;
        end
        if (ph_n == PH_SAMPLE && rate_q != 21'sd0) begin
          dir_q  <= (rate_q >= 0);
          dvs_q  <= {mag, 1'b0};
          rem_q  <= '0;
          quo_q  <= 21'(TickHz);
          dcnt_q <= 5'(DivBits);
        end
      end
      if (cmd_i.div && dcnt_q != 5'd0) begin
        if (rem_sh + 22'(quo_q[DivBits-1]) >= dvs_q) begin
          rem_q <= rem_sh + 22'(quo_q[DivBits-1]) - dvs_q;
          quo_q <= {quo_q[DivBits-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh + 22'(quo_q[DivBits-1]);
          quo_q <= {quo_q[DivBits-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
      end
      if (cmd_i.hp) begin
        // quotient fits 19 bits only when mag >= 1; saturate anyway
        if (quo_q > 21'(HalfMax)) begin
          half_q <= 19'(HalfMax); pcount_q <= 19'(HalfMax);
        end else if (quo_q < 21'(minhp_e)) begin
          half_q <= 19'(minhp_e); pcount_q <= 19'(minhp_e);
        end else begin
          half_q <= 19'(quo_q); pcount_q <= 19'(quo_q);
        end
        phase_q <= PH_HIGH;
      end
    end
  end

  assign stat_o.pid_due  = (pcnt_q + 16'd1 >= cper_e);
  assign stat_o.need_div = (ph_n == PH_SAMPLE) && (rate_q != 21'sd0);
  assign stat_o.div_done = (dcnt_q == 5'd0);

  assign step_o = (phase_q == PH_HIGH);
  assign dir_o  = dir_q;
  assign pos_o  = pos_q;
  assign rate_o = rate_q;
  assign err_o  = prev_err_q;
endmodule
`default_nettype wire

@@ src/quadrature_pid_stepper_position_loop.sv @@
`timescale 1ns / 1ps
// Quadrature encoder position loop with PID and step/direction output.
// Input stream: one transaction per time tick, tdata = {target_position,
// enc_b, enc_a}. Output stream: one transaction per tick with step level,
// direction, wrapped position, PID rate and error.
// A plain tick runs the states ENC, STEP and OUT after acceptance; a PID
// tick adds MUL_P, MUL_I, MUL_D and RATE after ENC, and when the step
// generator samples a nonzero rate the bit-serial 21-step divider (DIV) and
// the half-period load (HP) follow STEP; OUT then loads the output register
// and m_axis_tvalid. The next tick is taken once the result is in the output
// register; the divider and the three sequential PID multiplies set how long each tick takes.
// A stalled output holds the block in its output state and s_axis_tready
// stays low until the result is taken.
// Reset clears position, rate and step state; registers return to their defaults. The
// APB port writes registers at 4*index; write only while idle.
`default_nettype none
`include "quadrature_pid_stepper_position_loop_macros.svh"
module quadrature_pid_stepper_position_loop import qps_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // enc_a, enc_b, target_position[13:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // step_level, direction, position_now[14:0], rate_now[20:0], error_now[15:0]
  output logic [55:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  busy, out_load, in_fire;
  logic  step, dir;
  logic signed [14:0] pos;
  logic signed [20:0] rate;
  logic signed [15:0] err;
  reg_e  widx;

  assign pready = 1'b1;
  assign widx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp <= 16'sd2560; cfg_q.ki <= '0; cfg_q.kd <= '0;
      cfg_q.ilim <= 24'd1000000; cfg_q.cper <= 16'd1000; cfg_q.minhp <= 16'd50;
      cfg_q.tpr <= 15'd5000; cfg_q.idle <= 16'd1000;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_KP:    cfg_q.kp <= pwdata[15:0];
        REG_KI:    cfg_q.ki <= pwdata[15:0];
        REG_KD:    cfg_q.kd <= pwdata[15:0];
        REG_ILIM:  cfg_q.ilim <= pwdata[23:0];
        REG_CPER:  cfg_q.cper <= pwdata[15:0];
        REG_MINHP: cfg_q.minhp <= pwdata[15:0];
        REG_TPR:   cfg_q.tpr <= pwdata[14:0];
        REG_IDLE:  cfg_q.idle <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_KP:    prdata = 32'(unsigned'(cfg_q.kp));
      REG_KI:    prdata = 32'(unsigned'(cfg_q.ki));
      REG_KD:    prdata = 32'(unsigned'(cfg_q.kd));
      REG_ILIM:  prdata = 32'(cfg_q.ilim);
      REG_CPER:  prdata = 32'(cfg_q.cper);
      REG_MINHP: prdata = 32'(cfg_q.minhp);
      REG_TPR:   prdata = 32'(cfg_q.tpr);
      REG_IDLE:  prdata = 32'(cfg_q.idle);
      default:   prdata = '0;
    endcase
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  qps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(m_axis_tvalid && !m_axis_tready),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .out_load_o(out_load)
  );

  qps_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_i(cfg_q),
    .enc_a_i(s_axis_tdata[0]), .enc_b_i(s_axis_tdata[1]),
    .target_i(signed'(s_axis_tdata[15:2])), .stat_o(stat),
    .step_o(step), .dir_o(dir), .pos_o(pos), .rate_o(rate), .err_o(err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_axis_tdata <= {2'b00, err, rate, pos, dir, step};
  end

  `QPS_ASSERT_IMP(a_no_accept_busy, busy, !s_axis_tready, "accept while busy")
  `QPS_ASSERT_NXT(a_load_valid, out_load, m_axis_tvalid, "result not presented")
  `QPS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[55:54] == 2'b00, "pad bits set")
endmodule
`default_nettype wire
